// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the julia escape time pixel block
// expects aclk and aresetn in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/jet_pkg.sv -----
// shared types, constants and color rom builders for the julia escape time block
// no dependencies
`default_nettype none
package jet_pkg;

    localparam int STEP_LIMIT = 300;
    localparam int FRAC_BITS  = 26;
    localparam int Q_W        = 32;
    localparam int LEFT_W     = $clog2(STEP_LIMIT + 1);
    localparam int UQ         = 30;
    localparam int NUM_W      = 40;
    localparam int DIM_W      = 13;
    localparam int PIX_W      = 12;
    localparam int TINT_W     = 16;
    localparam int CFG_W      = 16;
    localparam int CNT_W      = $clog2(NUM_W);

    localparam logic [NUM_W-1:0] KQ_Y_SPAN =
        NUM_W'(((64'd18 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [NUM_W-1:0] KQ_X_SPAN =
        NUM_W'(((64'd32 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [Q_W-1:0] KQ_Y_OFS = Q_W'(((64'd9 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [Q_W-1:0] KQ_X_OFS = Q_W'(((64'd16 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic signed [63:0] KQ_CRE = 64'(((64'd79 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic signed [63:0] KQ_CIM = 64'(((64'd15 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic signed [63:0] FOUR_Q = 64'(64'd4 << FRAC_BITS);

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_TINT   = 2'd2;

    localparam int ROM_P3  = 0;
    localparam int ROM_P16 = 1;
    localparam int ROM_P03 = 2;

    typedef struct packed {
        logic             valid;
        logic [1:0]       index;
        logic [CFG_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic                  status;
        logic signed [Q_W-1:0] re;
        logic signed [Q_W-1:0] im;
    } work_t;

    typedef enum logic [1:0] {F_IDLE, F_DIVY, F_DIVX, F_PUSH} front_state_t;
    typedef enum logic [2:0] {B_IDLE, B_ITER, B_MUL, B_COL, B_OUT} back_state_t;

    typedef logic [UQ-1:0] rom_t [0:STEP_LIMIT];

    function automatic longint unsigned umul(input longint unsigned a,
                                             input longint unsigned b);
        return (a * b) >> UQ;
    endfunction

    function automatic longint unsigned upow(input longint unsigned t, input int k);
        longint unsigned r;
        r = longint'(1) << UQ;
        for (int i = 0; i < k; i++) begin
            r = umul(r, t);
        end
        return r;
    endfunction

    function automatic longint unsigned uroot(input longint unsigned v, input int k);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = longint'(1) << UQ;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (upow(mid, k) <= v) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return lo;
    endfunction

    function automatic rom_t build_rom(input int sel);
        rom_t            rom;
        longint unsigned c;
        longint unsigned p3;
        longint unsigned val;
        for (int l = 0; l <= STEP_LIMIT; l++) begin
            c  = (longint'(l) << UQ) / STEP_LIMIT;
            p3 = upow(c, 3);
            case (sel)
                ROM_P3:  val = p3;
                ROM_P16: val = umul(c, uroot(p3, 5));
                default: val = uroot(p3, 10);
            endcase
            rom[l] = UQ'(val);
        end
        return rom;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/julia_escape_time_pixel_top.sv -----
// julia escape time pixel colorer, top level: front, queue, back and config port
// a pixel outside the image skips the divisions and the escape iteration
// the front runs two restoring divisions, first for y and then for x
// the front takes a new pixel only after pushing the last one into the queue
// reset: synchronous active low, config back to 640 x 320 with tint 256, queue empty
// depends on jet_pkg, jet_front, jet_queue, jet_back and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module julia_escape_time_pixel_top (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [jet_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [jet_pkg::PIX_W-1:0]  s_pixel_x,
    input  wire logic [jet_pkg::PIX_W-1:0]  s_pixel_y,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [7:0]                      m_red,
    output logic [7:0]                      m_green,
    output logic [7:0]                      m_blue,
    output logic                            m_status
);
    import jet_pkg::*;

    cfg_wr_t cfg;
    work_t   push_data, pop_data;
    logic    q_push, q_ready, q_pop, q_valid;

    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    jet_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel_x (s_pixel_x),
        .s_pixel_y (s_pixel_y),
        .q_push    (q_push),
        .q_ready   (q_ready),
        .q_data    (push_data)
    );

    jet_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (push_data),
        .ready   (q_ready),
        .pop     (q_pop),
        .valid   (q_valid),
        .rdata   (pop_data)
    );

    jet_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_data   (pop_data),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_red    (m_red),
        .m_green  (m_green),
        .m_blue   (m_blue),
        .m_status (m_status)
    );

    `ASSERT_IMPL(a_status_black, m_valid && m_status, {m_red, m_green, m_blue} == 24'd0)
    `ASSERT_IMPL(a_pop_nonempty, q_pop, q_valid)
    `ASSERT_NEXT(a_pop_single, q_pop, !q_pop)

endmodule
`default_nettype wire

// ----- hw/rtl/jet_front.sv -----
// front end: range check and coordinate mapping with a shared restoring divider
// depends on jet_pkg
`default_nettype none
module jet_front (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire jet_pkg::cfg_wr_t       cfg,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [jet_pkg::PIX_W-1:0] s_pixel_x,
    input  wire logic [jet_pkg::PIX_W-1:0] s_pixel_y,
    output logic                        q_push,
    input  wire logic                   q_ready,
    output jet_pkg::work_t              q_data
);
    import jet_pkg::*;

    front_state_t     state_reg, state_next;
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [PIX_W-1:0] px_reg;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DIM_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg;
    work_t            item_reg;
    logic [DIM_W-1:0] divisor;
    logic [DIM_W:0]   trial;
    logic             ge;
    logic             accept, outside, last_step;

    assign accept    = s_valid && s_ready;
    assign outside   = ({1'b0, s_pixel_x} >= width_reg) || ({1'b0, s_pixel_y} >= height_reg);
    assign last_step = (cnt_reg == CNT_W'(NUM_W - 1));
    assign divisor   = (state_reg == F_DIVY) ? height_reg : width_reg;

    // one quotient bit per cycle
    always_comb begin
        trial    = {rem_reg, num_reg[NUM_W-1]};
        ge       = trial >= {1'b0, divisor};
        rem_next = ge ? DIM_W'(trial - {1'b0, divisor}) : DIM_W'(trial);
        num_next = {num_reg[NUM_W-2:0], ge};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: if (accept) state_next = outside ? F_PUSH : F_DIVY;
            F_DIVY: if (last_step) state_next = F_DIVX;
            F_DIVX: if (last_step) state_next = F_PUSH;
            F_PUSH: if (q_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == F_IDLE);
        q_push  = (state_reg == F_PUSH) && q_ready;
        q_data  = item_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= F_IDLE;
            width_reg  <= DIM_W'(640);
            height_reg <= DIM_W'(320);
        end else begin
            state_reg <= state_next;
            if (cfg.valid && cfg.index == CFG_WIDTH) width_reg <= cfg.data[DIM_W-1:0];
            if (cfg.valid && cfg.index == CFG_HEIGHT) height_reg <= cfg.data[DIM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            F_IDLE: begin
                px_reg          <= s_pixel_x;
                num_reg         <= KQ_Y_SPAN * NUM_W'(s_pixel_y);
                rem_reg         <= '0;
                cnt_reg         <= '0;
                item_reg.status <= outside;
                item_reg.re     <= '0;
                item_reg.im     <= '0;
            end
            F_DIVY: begin
                if (last_step) begin
                    item_reg.re <= num_next[Q_W-1:0] - KQ_Y_OFS;
                    num_reg     <= KQ_X_SPAN * NUM_W'(px_reg);
                    rem_reg     <= '0;
                    cnt_reg     <= '0;
                end else begin
                    num_reg <= num_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            F_DIVX: begin
                if (last_step) begin
                    item_reg.im <= num_next[Q_W-1:0] - KQ_X_OFS;
                end else begin
                    num_reg <= num_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/jet_queue.sv -----
// two entry queue between front and back
// depends on jet_pkg
`default_nettype none
module jet_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire jet_pkg::work_t wdata,
    output logic                ready,
    input  wire logic           pop,
    output logic                valid,
    output jet_pkg::work_t      rdata
);
    import jet_pkg::*;

    work_t      mem [0:1];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign ready = (count_reg != 2'd2);
    assign valid = (count_reg != 2'd0);
    assign rdata = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/jet_back.sv -----
// back end: escape iteration, color rom lookup and color scaling, output register
// depends on jet_pkg
`default_nettype none
module jet_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire jet_pkg::cfg_wr_t cfg,
    input  wire logic             q_valid,
    input  wire jet_pkg::work_t   q_data,
    output logic                  q_pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [7:0]            m_red,
    output logic [7:0]            m_green,
    output logic [7:0]            m_blue,
    output logic                  m_status
);
    import jet_pkg::*;

    localparam rom_t P3_ROM  = build_rom(ROM_P3);
    localparam rom_t P16_ROM = build_rom(ROM_P16);
    localparam rom_t P03_ROM = build_rom(ROM_P03);
    localparam int   SH      = UQ + 8;

    back_state_t           state_reg, state_next;
    logic [TINT_W-1:0]     tint_reg;
    logic [TINT_W+8:0]     tint500_reg;
    logic [TINT_W+7:0]     tint255_reg;
    logic signed [Q_W-1:0] re_reg, im_reg;
    logic [LEFT_W-1:0]     left_reg;
    logic [UQ-1:0]         p3_q, p16_q, p03_q;
    logic [TINT_W+8+UQ:0]  prod_r_reg;
    logic [TINT_W+7+UQ:0]  prod_b_reg;
    logic [UQ+7:0]         g_sum_reg;
    logic [7:0]            red_reg, green_reg, blue_reg;
    logic                  status_reg;
    logic                  m_valid_reg;
    logic                  out_free, load_out;
    logic signed [63:0]    p_ii, p_rr, p_ir, ii, rr, ir;
    logic                  escaped, exhausted;
    logic [TINT_W-1:0]     fl;
    logic                  exact;
    logic [7:0]            blue_byte;

    assign out_free  = !m_valid_reg || m_ready;
    assign exhausted = (left_reg == '0);

    always_comb begin
        p_ii    = 64'(im_reg) * 64'(im_reg);
        p_rr    = 64'(re_reg) * 64'(re_reg);
        p_ir    = 64'(im_reg) * 64'(re_reg);
        ii      = p_ii >>> FRAC_BITS;
        rr      = p_rr >>> FRAC_BITS;
        ir      = (p_ir <<< 1) >>> FRAC_BITS;
        escaped = (ii + rr) >= FOUR_Q;
    end

    // blue: truncate toward zero, then wrap
    always_comb begin
        fl    = prod_b_reg[SH+TINT_W-1:SH];
        exact = (prod_b_reg[SH-1:0] == '0);
        if (fl < TINT_W'(255) || (fl == TINT_W'(255) && exact)) begin
            blue_byte = 8'd255 - fl[7:0] - {7'd0, !exact};
        end else begin
            blue_byte = 8'd255 - fl[7:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: if (q_valid) state_next = q_data.status ? B_OUT : B_ITER;
            B_ITER: begin
                if (exhausted) state_next = B_OUT;
                else if (escaped) state_next = B_MUL;
            end
            B_MUL:  state_next = B_COL;
            B_COL:  state_next = B_OUT;
            B_OUT:  if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        q_pop    = (state_reg == B_IDLE) && q_valid;
        load_out = (state_reg == B_OUT) && out_free;
        m_valid  = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            tint_reg    <= TINT_W'(256);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg.valid && cfg.index == CFG_TINT) tint_reg <= cfg.data[TINT_W-1:0];
            if (load_out) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        tint500_reg <= (TINT_W+9)'(tint_reg) * (TINT_W+9)'(500);
        tint255_reg <= (TINT_W+8)'({tint_reg, 8'd0} - {8'd0, tint_reg});
        p3_q        <= P3_ROM[left_reg];
        p16_q       <= P16_ROM[left_reg];
        p03_q       <= P03_ROM[left_reg];
        if (load_out) begin
            m_red    <= red_reg;
            m_green  <= green_reg;
            m_blue   <= blue_reg;
            m_status <= status_reg;
        end
        case (state_reg)
            B_IDLE: begin
                re_reg     <= q_data.re;
                im_reg     <= q_data.im;
                left_reg   <= LEFT_W'(STEP_LIMIT);
                status_reg <= q_data.status;
                red_reg    <= '0;
                green_reg  <= '0;
                blue_reg   <= '0;
            end
            B_ITER: begin
                if (exhausted) begin
                    red_reg   <= 8'd200;
                    green_reg <= 8'd100;
                    blue_reg  <= 8'd100;
                end else if (!escaped) begin
                    im_reg   <= Q_W'(ii - rr - KQ_CRE);
                    re_reg   <= Q_W'(ir + KQ_CIM);
                    left_reg <= left_reg - 1'b1;
                end
            end
            B_MUL: begin
                prod_r_reg <= (TINT_W+9+UQ)'(tint500_reg) * (TINT_W+9+UQ)'(p16_q);
                prod_b_reg <= (TINT_W+8+UQ)'(tint255_reg) * (TINT_W+8+UQ)'(p3_q);
                g_sum_reg  <= {p03_q, 8'd0} - {8'd0, p03_q};
            end
            B_COL: begin
                red_reg   <= 8'd0 - prod_r_reg[SH+7:SH];
                green_reg <= 8'd0 - g_sum_reg[UQ+7:UQ];
                blue_reg  <= blue_byte;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// self-checking testbench for julia_escape_time_pixel_top: colors predicted in fixed point
// and compared beat by beat against the result channel, with random stalls on both sides
// depends on jet_pkg and the rtl of julia_escape_time_pixel_top
`default_nettype none
module testbench;
    import jet_pkg::*;

    localparam int    ITER_LIMIT  = 300;
    localparam int    QFRAC       = 26;
    localparam int    UFRAC       = 30;
    localparam longint CYCLE_LIMIT = 1500000;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam longint unsigned Y_SPAN = ((64'd18 << QFRAC) + 64'd5) / 64'd10;
    localparam longint unsigned X_SPAN = ((64'd32 << QFRAC) + 64'd5) / 64'd10;
    localparam longint Y_OFS  = ((64'd9 << QFRAC) + 64'd5) / 64'd10;
    localparam longint X_OFS  = ((64'd16 << QFRAC) + 64'd5) / 64'd10;
    localparam longint C_RE   = ((64'd79 << QFRAC) + 64'd50) / 64'd100;
    localparam longint C_IM   = ((64'd15 << QFRAC) + 64'd50) / 64'd100;
    localparam longint RADIUS = 64'd4 << QFRAC;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       status;
    } color_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_pixel_x;
    logic [PIX_W-1:0]     s_pixel_y;
    logic                 m_valid;
    logic                 m_ready;
    logic [7:0]           m_red;
    logic [7:0]           m_green;
    logic [7:0]           m_blue;
    logic                 m_status;

    longint unsigned cube_tab [0:ITER_LIMIT];
    longint unsigned pow16_tab [0:ITER_LIMIT];
    longint unsigned pow03_tab [0:ITER_LIMIT];

    int unsigned img_width;
    int unsigned img_height;
    int unsigned tint;

    color_t expected_colors [$];
    int     errors;
    int     pixels_sent;
    int     flagged_seen;
    int     bounded_seen;
    int     cfg_writes;
    longint cycles;
    bit     idle_en;
    int     out_stall;

    julia_escape_time_pixel_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel_x (s_pixel_x),
        .s_pixel_y (s_pixel_y),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_red     (m_red),
        .m_green   (m_green),
        .m_blue    (m_blue),
        .m_status  (m_status)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
        return (a * b) >> UFRAC;
    endfunction

    function automatic longint unsigned q30_power(longint unsigned t, int k);
        longint unsigned acc;
        acc = 64'd1 << UFRAC;
        for (int i = 0; i < k; i++) acc = q30_mul(acc, t);
        return acc;
    endfunction

    function automatic longint unsigned q30_root(longint unsigned v, int k);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 64'd1 << UFRAC;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (q30_power(mid, k) <= v) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic void fill_pow_tables();
        longint unsigned c;
        for (int n = 0; n <= ITER_LIMIT; n++) begin
            c = (longint'(n) << UFRAC) / ITER_LIMIT;
            cube_tab[n]  = q30_power(c, 3);
            pow16_tab[n] = q30_mul(c, q30_root(cube_tab[n], 5));
            pow03_tab[n] = q30_root(cube_tab[n], 10);
        end
    endfunction

    function automatic color_t pixel_color(int unsigned px, int unsigned py);
        color_t          res;
        longint          re;
        longint          im;
        longint          ii;
        longint          rr;
        longint          t;
        int              left;
        longint unsigned w;
        longint unsigned fl;
        longint unsigned cl;
        bit              exact;
        if (img_width == 0 || img_height == 0 || px >= img_width || py >= img_height) begin
            res = '{8'd0, 8'd0, 8'd0, 1'b1};
            return res;
        end
        re = longint'((Y_SPAN * py) / img_height) - Y_OFS;
        im = longint'((X_SPAN * px) / img_width) - X_OFS;
        left = ITER_LIMIT;
        while (left > 0) begin
            ii = (im * im) >>> QFRAC;
            rr = (re * re) >>> QFRAC;
            if (ii + rr >= RADIUS) break;
            t  = ii - rr - C_RE;
            re = ((2 * im * re) >>> QFRAC) + C_IM;
            im = t;
            left--;
        end
        if (left == 0) begin
            res = '{8'd200, 8'd100, 8'd100, 1'b0};
            return res;
        end
        res.status = 1'b0;
        res.red    = 8'(64'd0 - ((64'd500 * tint * pow16_tab[left]) >> (UFRAC + 8)));
        res.green  = 8'(64'd0 - ((64'd255 * pow03_tab[left]) >> UFRAC));
        w     = 64'd255 * tint * cube_tab[left];
        fl    = w >> (UFRAC + 8);
        exact = (w & ((64'd1 << (UFRAC + 8)) - 1)) == 0;
        cl    = fl + (exact ? 0 : 1);
        if (fl < 255 || (fl == 255 && exact)) res.blue = 8'(64'd255 - cl);
        else res.blue = 8'(64'd255 - fl);
        return res;
    endfunction

    // result side: random backpressure and comparison
    always @(posedge aclk) begin
        color_t exp_c;
        if (aresetn && m_valid && m_ready) begin
            if (expected_colors.size() == 0) begin
                $error("result beat with no pixel outstanding");
                errors++;
            end else begin
                exp_c = expected_colors.pop_front();
                if (m_red !== exp_c.red) begin
                    $error("red: expected %0d, got %0d", exp_c.red, m_red);
                    errors++;
                end
                if (m_green !== exp_c.green) begin
                    $error("green: expected %0d, got %0d", exp_c.green, m_green);
                    errors++;
                end
                if (m_blue !== exp_c.blue) begin
                    $error("blue: expected %0d, got %0d", exp_c.blue, m_blue);
                    errors++;
                end
                if (m_status !== exp_c.status) begin
                    $error("status: expected %0d, got %0d", exp_c.status, m_status);
                    errors++;
                end
                if (exp_c.status) flagged_seen++;
                else if (exp_c.red == 200 && exp_c.green == 100 && exp_c.blue == 100)
                    bounded_seen++;
            end
        end
        if (out_stall > 0) begin
            out_stall--;
            m_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            out_stall = $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("julia_escape_time_pixel_top: mismatch");
            $finish;
        end
    end

    task automatic send_pixel(int unsigned px, int unsigned py);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_pixel_x <= PIX_W'(px);
        s_pixel_y <= PIX_W'(py);
        do @(posedge aclk); while (!s_ready);
        expected_colors.push_back(pixel_color(px, py));
        pixels_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_colors.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_WIDTH:  img_width  = value & 32'h1FFF;
            CFG_HEIGHT: img_height = value & 32'h1FFF;
            CFG_TINT:   tint       = value & 32'hFFFF;
            default:    ;
        endcase
    endtask

    task automatic set_view(int unsigned w, int unsigned h, int unsigned tf);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_TINT, tf);
    endtask

    task automatic send_random(int count);
        int unsigned px;
        int unsigned py;
        for (int i = 0; i < count; i++) begin
            if (img_width != 0 && $urandom_range(0, 9) != 0)
                px = $urandom_range(0, (img_width > 4096 ? 4096 : img_width) - 1);
            else px = $urandom_range(0, 4095);
            if (img_height != 0 && $urandom_range(0, 9) != 0)
                py = $urandom_range(0, (img_height > 4096 ? 4096 : img_height) - 1);
            else py = $urandom_range(0, 4095);
            send_pixel(px, py);
        end
    endtask

    task automatic test_default_view();
        send_pixel(0, 0);
        send_pixel(639, 319);
        send_pixel(320, 160);
        send_pixel(640, 0);
        send_pixel(0, 320);
        send_pixel(4095, 4095);
        send_pixel(300, 150);
        drain();
    endtask

    task automatic test_full_canvas();
        set_view(4096, 4096, 65535);
        send_pixel(4095, 4095);
        send_pixel(0, 4095);
        send_pixel(4095, 0);
        send_pixel(2048, 2048);
        send_pixel(2730, 1365);
        send_random(40);
        drain();
    endtask

    task automatic test_degenerate_sizes();
        set_view(1, 1, 0);
        send_pixel(0, 0);
        send_pixel(1, 0);
        send_pixel(0, 1);
        drain();
        set_view(0, 8, 256);
        send_pixel(0, 0);
        drain();
        // upper data bits are dropped by the 13-bit registers
        set_view(16'hE00A, 16'hFFFF, 512);
        send_pixel(9, 5);
        send_pixel(10, 0);
        drain();
    endtask

    task automatic test_unused_index();
        write_reg(CFG_UNUSED, 16'h0001);
        send_pixel(320, 160);
        send_pixel(5, 5);
        drain();
    endtask

    task automatic test_random_views();
        set_view(640, 320, 256);
        send_random(110);
        drain();
        for (int ph = 0; ph < 3; ph++) begin
            set_view($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(0, 65535));
            send_random(100);
            drain();
        end
        idle_en = 1'b0;
        set_view($urandom_range(2, 200), $urandom_range(2, 200), $urandom_range(128, 1024));
        send_random(90);
        drain();
    endtask

    initial begin
        aclk      = 1'b0;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_pixel_x = '0;
        s_pixel_y = '0;
        m_ready   = 1'b0;
        errors = 0; pixels_sent = 0; flagged_seen = 0; bounded_seen = 0;
        cfg_writes = 0; cycles = 0; out_stall = 0; idle_en = 1'b1;
        img_width = 640; img_height = 320; tint = 256;
        fill_pow_tables();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_view();
        test_full_canvas();
        test_degenerate_sizes();
        test_unused_index();
        test_random_views();

        $display("covered %0d pixels over %0d register writes", pixels_sent, cfg_writes);
        $display("%0d flagged outside the image, %0d never escaped", flagged_seen,
                 bounded_seen);
        if (errors == 0) $display("julia_escape_time_pixel_top: match");
        else $display("julia_escape_time_pixel_top: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
